// ===== hdl/gpcs_pkg.sv =====
// Package of the gauge pot calibration sequencer: beat types, operation and
// phase codes, register indexes and reset constants.
// Has no dependencies; gpcs_trim, the top level and the testbench import it.
`default_nettype none

package gpcs_pkg;

  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
  localparam logic [POS_W-1:0] POS_MID = 10'd512;

  localparam logic [9:0]  TARGET_MIN_RST  = 10'd20;
  localparam logic [9:0]  TARGET_WITH_RST = 10'd700;
  localparam logic [7:0]  TOL_RST         = 8'd5;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
  localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

  localparam logic [2:0] REG_TARGET_MIN_AMP     = 3'd0;
  localparam logic [2:0] REG_TARGET_WITH_AMP    = 3'd1;
  localparam logic [2:0] REG_TOLERANCE_NO_AMP   = 3'd2;
  localparam logic [2:0] REG_TOLERANCE_WITH_AMP = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_TICKS      = 3'd4;

  typedef enum logic [2:0] {
    OP_SAMPLE       = 3'd0,
    OP_TICK         = 3'd1,
    OP_START_FULL   = 3'd2,
    OP_START_BRIDGE = 3'd3,
    OP_START_AMP    = 3'd4,
    OP_START_CONST  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_BRIDGE_MIN   = 3'd1,
    PH_FULL         = 3'd2,
    PH_AMP          = 3'd3,
    PH_BRIDGE_CONST = 3'd4
  } phase_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] gauge_index;
    logic [9:0] sample;
    logic       end_of_scan;
  } in_t;

  typedef struct packed {
    logic [3:0]       out_gauge;
    logic [9:0]       out_sample;
    logic [POS_W-1:0] bridge_position;
    logic [POS_W-1:0] amp_position;
    logic             gauge_complete;
    logic             gauge_broken;
    logic [2:0]       phase;
  } out_t;

  typedef struct packed {
    logic             broken;
    logic [POS_W-1:0] amp;
    logic [POS_W-1:0] bridge;
  } entry_t;

  localparam entry_t ENTRY_RST = '{broken: 1'b0, amp: POS_MID, bridge: POS_MID};

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             done;
    logic             broken;
  } trim_res_t;

endpackage

`default_nettype wire

// ===== hdl/gpcs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies; used for the per-gauge pot position store.
`default_nettype none

module gpcs_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gpcs_trim.sv =====
// One trim step of a potentiometer against a target window.
// Depends on gpcs_pkg for the position width, bound and result struct.
`default_nettype none

module gpcs_trim (
  input  wire logic [gpcs_pkg::POS_W-1:0] pos_i,
  input  wire logic                       done_i,
  input  wire logic                       broken_i,
  input  wire logic [9:0]                 sample_i,
  input  wire logic [9:0]                 target_i,
  input  wire logic [7:0]                 tol_i,
  output gpcs_pkg::trim_res_t             res_o
);
  import gpcs_pkg::*;

  logic signed [11:0] lo;
  logic signed [11:0] hi;
  logic signed [11:0] smp;

  assign lo  = $signed({2'b00, target_i}) - $signed({4'b0000, tol_i});
  assign hi  = $signed({2'b00, target_i}) + $signed({4'b0000, tol_i});
  assign smp = $signed({2'b00, sample_i});

  always_comb begin
    res_o.pos    = pos_i;
    res_o.done   = done_i;
    res_o.broken = broken_i;
    if (!done_i) begin
      if (smp < lo) begin
        if (pos_i == '0) begin
          res_o.done   = 1'b1;
          res_o.broken = 1'b1;
        end else begin
          res_o.pos = pos_i - POS_W'(1);
        end
      end else if (smp > hi) begin
        if (pos_i == POS_MAX) begin
          res_o.done   = 1'b1;
          res_o.broken = 1'b1;
        end else begin
          res_o.pos = pos_i + POS_W'(1);
        end
      end else begin
        res_o.done = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gauge_pot_calibration_sequencer.sv =====
// Top level of the gauge pot calibration sequencer.
// Depends on gpcs_pkg, gpcs_ram and gpcs_trim.
//
// Items arrive on the in channel (valid/ready); each beat carries an operation:
// a sample, a tick, or a start of one of the calibration phases. Every sample
// of a gauge below GAUGES yields one beat on the out channel with the pot
// positions, done and broken state of that gauge and the phase after the step.
// Ticks, starts, unused codes and out-of-range gauges yield no beat.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while the block is idle.
// Per-gauge positions and broken flags sit in a RAM with a registered read
// port. An item reads its entry in the cycle it is accepted and is modified
// and written back in the modify stage, where its result is loaded into the
// output register; the modify stage waits while the output is stalled.
// A write to the entry that the following item reads is forwarded.
// Without stalls, throughput is one item per cycle (read-modify-write loop).
// After reset all entries read as mid-scale and not broken through per-entry
// valid bits; no clearing pass runs, so items are accepted right away.
// When the receiver stalls, the output register holds its beat, the item in
// the modify stage waits and in_ready_o drops until the beat is taken.
`default_nettype none

module gauge_pot_calibration_sequencer #(
  parameter int unsigned GAUGES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire gpcs_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output gpcs_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [2:0]     cfg_index_i,
  input  wire logic [15:0]    cfg_data_i
);
  import gpcs_pkg::*;

  localparam int unsigned AW = (GAUGES > 1) ? $clog2(GAUGES) : 1;
  localparam int unsigned EW = $bits(entry_t);

  logic [9:0]  target_min_q;
  logic [9:0]  target_with_q;
  logic [7:0]  tol_no_q;
  logic [7:0]  tol_with_q;
  logic [15:0] timeout_q;

  logic [2:0]        phase_q, phase_d;
  logic [15:0]       elapsed_q, elapsed_d;
  logic              sad_q, sad_d;
  logic [GAUGES-1:0] bridge_done_q, bridge_done_d;
  logic [GAUGES-1:0] amp_done_q, amp_done_d;
  logic [GAUGES-1:0] valid_q;

  logic    s1_valid_q;
  in_t     s1_item_q;
  logic    fwd_q;
  entry_t  fwd_data_q;
  logic    s1_fire;
  logic    in_accept;
  logic    in_range;
  logic [AW-1:0] s1_addr;
  logic [AW-1:0] rd_addr;

  logic          wr_en;
  entry_t        wr_data;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_entry;

  logic             sel_amp;
  logic [9:0]       trim_target;
  logic [7:0]       trim_tol;
  trim_res_t        trim_res;

  logic   res_valid;
  out_t   res;
  logic   out_valid_q;
  out_t   out_q;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign in_accept   = in_valid_i && in_ready_o;
  assign rd_addr     = AW'(in_data_i.gauge_index);
  assign s1_addr     = AW'(s1_item_q.gauge_index);
  assign in_range    = int'(s1_item_q.gauge_index) < GAUGES;

  gpcs_ram #(
    .WIDTH(EW),
    .DEPTH(GAUGES)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_addr),
    .wdata_i(wr_data),
    .re_i   (in_accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (fwd_q) begin
      rd_entry = fwd_data_q;
    end else if (valid_q[s1_addr]) begin
      rd_entry = entry_t'(ram_rdata);
    end else begin
      rd_entry = ENTRY_RST;
    end
  end

  always_comb begin
    sel_amp     = 1'b0;
    trim_target = target_min_q;
    trim_tol    = tol_no_q;
    case (phase_q)
      PH_AMP: begin
        sel_amp     = 1'b1;
        trim_target = target_with_q;
        trim_tol    = tol_with_q;
      end
      PH_BRIDGE_CONST: begin
        trim_target = target_with_q;
        trim_tol    = tol_with_q;
      end
      default: ;
    endcase
  end

  gpcs_trim u_trim (
    .pos_i   (sel_amp ? rd_entry.amp : rd_entry.bridge),
    .done_i  (sel_amp ? amp_done_q[s1_addr] : bridge_done_q[s1_addr]),
    .broken_i(rd_entry.broken),
    .sample_i(s1_item_q.sample),
    .target_i(trim_target),
    .tol_i   (trim_tol),
    .res_o   (trim_res)
  );

  always_comb begin
    logic comp;
    logic sad_v;
    phase_d       = phase_q;
    elapsed_d     = elapsed_q;
    sad_d         = sad_q;
    bridge_done_d = bridge_done_q;
    amp_done_d    = amp_done_q;
    wr_en         = 1'b0;
    wr_data       = rd_entry;
    res_valid     = 1'b0;
    comp          = bridge_done_q[s1_addr] && amp_done_q[s1_addr];
    sad_v         = sad_q;
    if (s1_fire) begin
      case (op_e'(s1_item_q.operation))
        OP_TICK: begin
          if (elapsed_q != TICKS_MAX) begin
            elapsed_d = elapsed_q + 16'd1;
          end
        end
        OP_START_FULL: begin
          bridge_done_d = '0;
          amp_done_d    = '0;
          phase_d       = PH_FULL;
          elapsed_d     = '0;
          sad_d         = 1'b1;
        end
        OP_START_BRIDGE: begin
          bridge_done_d = '0;
          phase_d       = PH_BRIDGE_MIN;
          elapsed_d     = '0;
          sad_d         = 1'b1;
        end
        OP_START_AMP: begin
          amp_done_d = '0;
          phase_d    = PH_AMP;
          elapsed_d  = '0;
          sad_d      = 1'b1;
        end
        OP_START_CONST: begin
          bridge_done_d = '0;
          phase_d       = PH_BRIDGE_CONST;
          elapsed_d     = '0;
          sad_d         = 1'b1;
        end
        OP_SAMPLE: begin
          if (in_range) begin
            res_valid = 1'b1;
            if (phase_q != PH_IDLE) begin
              wr_en          = 1'b1;
              wr_data.broken = trim_res.broken;
              if (sel_amp) begin
                wr_data.amp         = trim_res.pos;
                amp_done_d[s1_addr] = trim_res.done;
              end else begin
                wr_data.bridge         = trim_res.pos;
                bridge_done_d[s1_addr] = trim_res.done;
              end
              comp  = trim_res.done;
              sad_v = sad_q && comp;
              if (s1_item_q.end_of_scan && (sad_v || elapsed_q > timeout_q)) begin
                phase_d   = (phase_q == PH_FULL) ? PH_AMP : PH_IDLE;
                elapsed_d = '0;
              end
            end
            sad_d = s1_item_q.end_of_scan ? 1'b1 : sad_v;
          end
        end
        default: ;
      endcase
    end
    res.out_gauge       = s1_item_q.gauge_index;
    res.out_sample      = s1_item_q.sample;
    res.bridge_position = wr_data.bridge;
    res.amp_position    = wr_data.amp;
    res.gauge_complete  = comp;
    res.gauge_broken    = wr_data.broken;
    res.phase           = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_min_q  <= TARGET_MIN_RST;
      target_with_q <= TARGET_WITH_RST;
      tol_no_q      <= TOL_RST;
      tol_with_q    <= TOL_RST;
      timeout_q     <= TIMEOUT_RST;
      phase_q       <= PH_IDLE;
      elapsed_q     <= '0;
      sad_q         <= 1'b1;
      bridge_done_q <= '1;
      amp_done_q    <= '1;
      valid_q       <= '0;
      s1_valid_q    <= 1'b0;
      fwd_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TARGET_MIN_AMP:     target_min_q  <= cfg_data_i[9:0];
          REG_TARGET_WITH_AMP:    target_with_q <= cfg_data_i[9:0];
          REG_TOLERANCE_NO_AMP:   tol_no_q      <= cfg_data_i[7:0];
          REG_TOLERANCE_WITH_AMP: tol_with_q    <= cfg_data_i[7:0];
          REG_TIMEOUT_TICKS:      timeout_q     <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      sad_q         <= sad_d;
      bridge_done_q <= bridge_done_d;
      amp_done_q    <= amp_done_d;
      if (wr_en) begin
        valid_q[s1_addr] <= 1'b1;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= wr_en && (s1_addr == rd_addr);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q  <= in_data_i;
      fwd_data_q <= wr_data;
    end
    if (s1_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_phase_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != $past(phase_q) && phase_q != PH_IDLE) |->
      ($past(s1_fire) && ($past(s1_item_q.operation) != OP_SAMPLE ||
                          $past(phase_q) == PH_FULL)))
    else $error("phase entered without a start or the end of the bridge phase");

  a_ticks_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elapsed_q != $past(elapsed_q)) |->
      (elapsed_q == $past(elapsed_q) + 16'd1 || elapsed_q == '0))
    else $error("tick counter moved by more than one step");

  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res_valid) |=>
      (out_valid_q && out_q.out_gauge == $past(s1_item_q.gauge_index)))
    else $error("result beat of the modify stage was not loaded");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_fire && phase_q != PH_IDLE && in_range))
    else $error("position store written outside a trim step");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench of gauge_pot_calibration_sequencer: a directed table, a rail
// run, then random calibration scans, checked against a gauge-bank model or, for typed rows, listed beats.
// Depends on gpcs_pkg and the block's RTL.
`default_nettype none

module tb;
  import gpcs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_ITEMS = 250;
  localparam logic [2:0] OP_RESERVED_6 = 3'd6;
  localparam logic [2:0] OP_RESERVED_7 = 3'd7;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    in_t         item;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    out_t        beat;
  } row_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             done;
    logic             broken;
  } pot_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t in_data = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;
  logic cfg_ready_o;

  gauge_pot_calibration_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // Gauge bank model and its register copy.
  logic [9:0]  tgt_min = TARGET_MIN_RST;
  logic [9:0]  tgt_with = TARGET_WITH_RST;
  logic [7:0]  tol_no = TOL_RST;
  logic [7:0]  tol_with = TOL_RST;
  logic [15:0] timeout_lim = TIMEOUT_RST;

  logic [POS_W-1:0] bridge_pos_m [16];
  logic [POS_W-1:0] amp_pos_m [16];
  bit               bridge_done_m [16];
  bit               amp_done_m [16];
  bit               broken_m [16];
  phase_e           phase_m = PH_IDLE;
  logic [15:0]      ticks_m = '0;
  bit               scan_done_m = 1'b1;

  out_t pending_reports [$];
  int   mismatches = 0;
  int   items_done = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;
  out_t want_beat;

  initial begin
    for (int g = 0; g < 16; g++) begin
      bridge_pos_m[g] = POS_MID;
      amp_pos_m[g] = POS_MID;
      bridge_done_m[g] = 1'b1;
      amp_done_m[g] = 1'b1;
      broken_m[g] = 1'b0;
    end
  end

  function automatic out_t report(logic [3:0] g, logic [9:0] s, logic [9:0] br,
                                  logic [9:0] am, bit comp, bit brk, logic [2:0] ph);
    out_t b;
    b.out_gauge = g;
    b.out_sample = s;
    b.bridge_position = br;
    b.amp_position = am;
    b.gauge_complete = comp;
    b.gauge_broken = brk;
    b.phase = ph;
    return b;
  endfunction

  function automatic in_t mk_item(logic [2:0] op, logic [3:0] g, logic [9:0] s, bit eos);
    in_t it;
    it.operation = op;
    it.gauge_index = g;
    it.sample = s;
    it.end_of_scan = eos;
    return it;
  endfunction

  function automatic pot_step_t pot_step(logic [POS_W-1:0] pos, bit done, bit broken,
                                         logic [9:0] s, logic [9:0] target, logic [7:0] tol);
    int lo;
    int hi;
    int sv;
    pot_step_t r;
    lo = target;
    hi = target;
    sv = s;
    lo = lo - int'(tol);
    hi = hi + int'(tol);
    r.pos = pos;
    r.done = done;
    r.broken = broken;
    if (!done) begin
      if (sv < lo) begin
        if (pos == '0) begin
          r.done = 1'b1;
          r.broken = 1'b1;
        end else begin
          r.pos = pos - POS_W'(1);
        end
      end else if (sv > hi) begin
        if (pos == POS_MAX) begin
          r.done = 1'b1;
          r.broken = 1'b1;
        end else begin
          r.pos = pos + POS_W'(1);
        end
      end else begin
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic begin_phase(phase_e ph, bit clr_bridge, bit clr_amp);
    for (int g = 0; g < 16; g++) begin
      if (clr_bridge) bridge_done_m[g] = 1'b0;
      if (clr_amp) amp_done_m[g] = 1'b0;
    end
    phase_m = ph;
    ticks_m = '0;
    scan_done_m = 1'b1;
  endtask

  // Applies one accepted item to the model and queues the gauge report it causes.
  task automatic advance_sequencer(in_t it, bit typed, out_t beat);
    logic [3:0] g;
    logic [9:0] tg;
    logic [7:0] tl;
    pot_step_t st;
    bit comp;
    g = it.gauge_index;
    case (it.operation)
      OP_TICK: begin
        if (ticks_m != TICKS_MAX) ticks_m = ticks_m + 16'd1;
      end
      OP_START_FULL:   begin_phase(PH_FULL, 1'b1, 1'b1);
      OP_START_BRIDGE: begin_phase(PH_BRIDGE_MIN, 1'b1, 1'b0);
      OP_START_AMP:    begin_phase(PH_AMP, 1'b0, 1'b1);
      OP_START_CONST:  begin_phase(PH_BRIDGE_CONST, 1'b1, 1'b0);
      OP_SAMPLE: begin
        comp = bridge_done_m[g] && amp_done_m[g];
        if (phase_m == PH_AMP) begin
          st = pot_step(amp_pos_m[g], amp_done_m[g], broken_m[g], it.sample,
                        tgt_with, tol_with);
          amp_pos_m[g] = st.pos;
          amp_done_m[g] = st.done;
          broken_m[g] = st.broken;
          comp = st.done;
        end else if (phase_m != PH_IDLE) begin
          tg = (phase_m == PH_BRIDGE_CONST) ? tgt_with : tgt_min;
          tl = (phase_m == PH_BRIDGE_CONST) ? tol_with : tol_no;
          st = pot_step(bridge_pos_m[g], bridge_done_m[g], broken_m[g], it.sample, tg, tl);
          bridge_pos_m[g] = st.pos;
          bridge_done_m[g] = st.done;
          broken_m[g] = st.broken;
          comp = st.done;
        end
        if (phase_m != PH_IDLE) begin
          if (!comp) scan_done_m = 1'b0;
          if (it.end_of_scan && (scan_done_m || ticks_m > timeout_lim)) begin
            phase_m = (phase_m == PH_FULL) ? PH_AMP : PH_IDLE;
            ticks_m = '0;
          end
        end
        if (it.end_of_scan) scan_done_m = 1'b1;
        pending_reports.push_back(typed ? beat :
          report(g, it.sample, bridge_pos_m[g], amp_pos_m[g], comp, broken_m[g], phase_m));
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_item(in_t it, bit typed, out_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    advance_sequencer(it, typed, beat);
    if (it.operation <= OP_START_CONST) items_done++;
  endtask

  task automatic send(logic [2:0] op, logic [3:0] g, logic [9:0] s, bit eos);
    send_item(mk_item(op, g, s, eos), 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      REG_TARGET_MIN_AMP:     tgt_min = val[9:0];
      REG_TARGET_WITH_AMP:    tgt_with = val[9:0];
      REG_TOLERANCE_NO_AMP:   tol_no = val[7:0];
      REG_TOLERANCE_WITH_AMP: tol_with = val[7:0];
      REG_TIMEOUT_TICKS:      timeout_lim = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] t_min, logic [15:0] t_with, logic [15:0] t_no,
                           logic [15:0] t_wtol, logic [15:0] t_out);
    wait_idle();
    write_reg(REG_TARGET_MIN_AMP, t_min);
    write_reg(REG_TARGET_WITH_AMP, t_with);
    write_reg(REG_TOLERANCE_NO_AMP, t_no);
    write_reg(REG_TOLERANCE_WITH_AMP, t_wtol);
    write_reg(REG_TIMEOUT_TICKS, t_out);
    cfg_valid <= 1'b0;
  endtask

  // Samples cluster around the window of the running phase so gauges both step and settle.
  function automatic logic [9:0] near_sample();
    int tg;
    int tl;
    int v;
    tg = (phase_m == PH_AMP || phase_m == PH_BRIDGE_CONST) ? tgt_with : tgt_min;
    tl = (phase_m == PH_AMP || phase_m == PH_BRIDGE_CONST) ? tol_with : tol_no;
    if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
    v = tg - tl - 3 + $urandom_range(0, 2 * tl + 6);
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  task automatic run_episode();
    int scans;
    int last;
    logic [2:0] op;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: op = OP_START_FULL;
        1: op = OP_START_BRIDGE;
        2: op = OP_START_AMP;
        default: op = OP_START_CONST;
      endcase
      send(op, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
           1'($urandom_range(0, 1)));
      scans = $urandom_range(1, 6);
      repeat (scans) begin
        last = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 15;
        for (int g = 0; g <= last; g++) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3))
              send(OP_TICK, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
                   1'($urandom_range(0, 1)));
          end
          send(OP_SAMPLE, 4'(g), near_sample(), g == last);
        end
      end
    end else begin
      repeat ($urandom_range(5, 20))
        send(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
             10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic row_t plain_row(logic [2:0] op, logic [3:0] g, logic [9:0] s, bit eos);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = mk_item(op, g, s, eos);
    return r;
  endfunction

  function automatic row_t typed_row(logic [2:0] op, logic [3:0] g, logic [9:0] s, bit eos,
                                     out_t beat);
    row_t r;
    r = plain_row(op, g, s, eos);
    r.kind = ROW_TYPED;
    r.beat = beat;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    row_t plan [$];
    bit cfg_open;
    int base;
    int round;
    int round_base;
    int gr;
    cfg_open = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan.push_back(typed_row(OP_SAMPLE, 0, 0, 0, report(0, 0, POS_MID, POS_MID, 1, 0, PH_IDLE)));
    plan.push_back(typed_row(OP_SAMPLE, 15, 1023, 1,
                             report(15, 1023, POS_MID, POS_MID, 1, 0, PH_IDLE)));
    plan.push_back(plain_row(OP_TICK, 0, 0, 0));
    plan.push_back(plain_row(OP_RESERVED_6, 3, 5, 1));
    plan.push_back(plain_row(OP_RESERVED_7, 15, 1023, 1));
    plan.push_back(plain_row(OP_START_BRIDGE, 0, 0, 0));
    plan.push_back(typed_row(OP_SAMPLE, 0, 0, 0,
                             report(0, 0, 10'd511, POS_MID, 0, 0, PH_BRIDGE_MIN)));
    plan.push_back(typed_row(OP_SAMPLE, 1, 1023, 0,
                             report(1, 1023, 10'd513, POS_MID, 0, 0, PH_BRIDGE_MIN)));
    plan.push_back(plain_row(OP_SAMPLE, 2, 20, 1));
    plan.push_back(plain_row(OP_START_FULL, 0, 0, 0));
    plan.push_back(plain_row(OP_SAMPLE, 0, 20, 1));
    plan.push_back(plain_row(OP_SAMPLE, 0, 1023, 0));
    plan.push_back(plain_row(OP_START_CONST, 0, 0, 0));
    plan.push_back(plain_row(OP_SAMPLE, 4, 0, 1));
    plan.push_back(plain_row(OP_START_AMP, 0, 0, 0));
    plan.push_back(plain_row(OP_SAMPLE, 5, 700, 1));
    plan.push_back(cfg_row(REG_TARGET_MIN_AMP, 16'd3));
    plan.push_back(cfg_row(REG_TOLERANCE_NO_AMP, 16'd5));
    plan.push_back(cfg_row(REG_TIMEOUT_TICKS, 16'd0));
    plan.push_back(plain_row(OP_START_BRIDGE, 0, 0, 0));
    plan.push_back(typed_row(OP_SAMPLE, 6, 0, 0,
                             report(6, 0, POS_MID, POS_MID, 1, 0, PH_BRIDGE_MIN)));
    plan.push_back(plain_row(OP_TICK, 0, 0, 0));
    plan.push_back(plain_row(OP_SAMPLE, 7, 1023, 1));
    plan.push_back(cfg_row(REG_TARGET_WITH_AMP, 16'd1023));
    plan.push_back(cfg_row(REG_TOLERANCE_WITH_AMP, 16'd255));
    plan.push_back(plain_row(OP_START_AMP, 0, 0, 0));
    plan.push_back(plain_row(OP_SAMPLE, 8, 1023, 0));
    plan.push_back(plain_row(OP_SAMPLE, 9, 0, 1));
    plan.push_back(plain_row(OP_START_CONST, 0, 0, 0));
    plan.push_back(plain_row(OP_SAMPLE, 10, 767, 1));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (!cfg_open) wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_item(plan[i].item, plan[i].kind == ROW_TYPED, plan[i].beat);
      end
    end

    // Drive one bridge pot onto the bottom rail.
    configure(16'd20, 16'd700, 16'd5, 16'd5, 16'd1000);
    gr = $urandom_range(0, 15);
    send(OP_START_BRIDGE, 0, 0, 0);
    repeat (514) send(OP_SAMPLE, 4'(gr), 0, 0);

    base = items_done;
    round = 0;
    while (items_done - base < RANDOM_ITEMS) begin
      case (round)
        0: configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: configure(16'd1023, 16'd1023, 16'd255, 16'd255, 16'hFFFF);
        default: configure(16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 60) : $urandom),
                           16'($urandom), {8'($urandom), 8'($urandom_range(0, 12))},
                           16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12)),
                           16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 30)));
      endcase
      round_base = items_done;
      while (items_done - round_base < 100) run_episode();
      round++;
    end

    wait_idle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (calm || $urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 255) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("gauge report beat with none expected: %h", out_data_o);
        mismatches++;
      end else begin
        want_beat = pending_reports.pop_front();
        check_field("out_gauge", want_beat.out_gauge, out_data_o.out_gauge);
        check_field("out_sample", want_beat.out_sample, out_data_o.out_sample);
        check_field("bridge_position", want_beat.bridge_position, out_data_o.bridge_position);
        check_field("amp_position", want_beat.amp_position, out_data_o.amp_position);
        check_field("gauge_complete", want_beat.gauge_complete, out_data_o.gauge_complete);
        check_field("gauge_broken", want_beat.gauge_broken, out_data_o.gauge_broken);
        check_field("phase", want_beat.phase, out_data_o.phase);
      end
    end
  end

endmodule

`default_nettype wire
